>>> rtl/core/stepwise_remote_volume_sync_top_assert.svh
// assertion macros for the remote volume sync block
`ifndef STEPWISE_REMOTE_VOLUME_SYNC_TOP_ASSERT_SVH
`define STEPWISE_REMOTE_VOLUME_SYNC_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define SRV_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("srv assertion failed");

// next-cycle implication, off during reset
`define SRV_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("srv assertion failed");

`endif

>>> rtl/core/srv_sync_pkg.sv
package srv_sync_pkg;

  localparam int MAX_LEVEL = 15;

  typedef logic signed [4:0] level_t;

  localparam level_t LEVEL_TOP     = level_t'((MAX_LEVEL < 15) ? MAX_LEVEL : 15);
  localparam level_t LEVEL_FLOOR   = -5'sd16;
  localparam level_t LEVEL_UNSYNC  = -5'sd1;
  localparam level_t LEVEL_ZERO    = 5'sd0;
  localparam level_t LEVEL_ONE     = 5'sd1;

  typedef enum logic [1:0] {
    REQ_TARGET = 2'd0,
    REQ_DONE   = 2'd1,
    REQ_STOP   = 2'd2,
    REQ_RESET  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    MODE_WAIT        = 3'd0,
    MODE_DELAY       = 3'd1,
    MODE_UP_TIMING   = 3'd2,
    MODE_UP          = 3'd3,
    MODE_DOWN_TIMING = 3'd4,
    MODE_DOWN        = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_SHORT = 3'd1,
    ACT_LONG  = 3'd2,
    ACT_UP    = 3'd3,
    ACT_DOWN  = 3'd4
  } act_t;

endpackage

>>> rtl/core/stepwise_remote_volume_sync_top.sv
// Stepwise remote volume sync: each event transfer (new target, completion of
// the pending timer or command, stop, reset) yields exactly one result giving
// the action to start, the mode afterwards and the believed remote level.
// Events enter an input register and are evaluated combinationally into the
// result register, so the block takes one event per cycle while the result
// is not stalled. The input register can hold one more event while a
// result waits, and in_stall rises only when both the input and result
// registers are full and the result is stalled.
`include "stepwise_remote_volume_sync_top_assert.svh"

module stepwise_remote_volume_sync_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        req_type,
  input  logic signed [4:0] new_volume,
  input  logic              completion_error,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        action,
  output logic [2:0]        mode,
  output logic signed [4:0] remote_level
);

  // input register
  logic                    s1_valid;
  srv_sync_pkg::req_t      s1_req;
  srv_sync_pkg::level_t    s1_vol;
  logic                    s1_err;
  logic                    s1_move;

  // block state
  srv_sync_pkg::mode_t     mode_reg;
  srv_sync_pkg::level_t    target_level;
  srv_sync_pkg::level_t    applied_level;
  srv_sync_pkg::level_t    remote_reg;
  logic                    busy_reg;

  // next values
  srv_sync_pkg::mode_t     mode_next;
  srv_sync_pkg::level_t    target_next;
  srv_sync_pkg::level_t    applied_next;
  srv_sync_pkg::level_t    remote_next;
  logic                    busy_next;
  srv_sync_pkg::act_t      act_next;

  srv_sync_pkg::mode_t     mode_prior;
  srv_sync_pkg::level_t    prev;
  srv_sync_pkg::act_t      want;
  logic                    do_cancel;
  logic                    do_count;
  logic                    do_adv;

  assign s1_move  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_move;

  always_comb begin
    mode_next    = mode_reg;
    target_next  = target_level;
    applied_next = applied_level;
    remote_next  = remote_reg;
    busy_next    = busy_reg;
    act_next     = srv_sync_pkg::ACT_NONE;
    mode_prior   = mode_reg;
    prev         = applied_level;
    want         = srv_sync_pkg::ACT_NONE;
    do_cancel    = 1'b0;
    do_count     = 1'b0;
    do_adv       = 1'b0;

    unique case (s1_req)
      srv_sync_pkg::REQ_TARGET: begin
        target_next = s1_vol;
        if (remote_reg == srv_sync_pkg::LEVEL_UNSYNC) begin
          remote_next = s1_vol;
        end else if (mode_reg == srv_sync_pkg::MODE_WAIT) begin
          do_adv = 1'b1;
        end else if (mode_reg == srv_sync_pkg::MODE_DELAY) begin
          do_cancel = 1'b1;
          do_adv    = 1'b1;
        end
      end
      srv_sync_pkg::REQ_DONE: begin
        if (busy_reg) begin
          busy_next = 1'b0;
          if (!s1_err) begin
            do_count = 1'b1;
            do_adv   = 1'b1;
          end
        end
      end
      srv_sync_pkg::REQ_STOP:  do_cancel = 1'b1;
      srv_sync_pkg::REQ_RESET: do_cancel = 1'b1;
    endcase

    // a cancelled command still counts its step
    if (do_cancel && busy_reg) begin
      do_count  = 1'b1;
      busy_next = 1'b0;
    end

    if (do_count) begin
      if (mode_reg == srv_sync_pkg::MODE_UP && remote_next < srv_sync_pkg::LEVEL_TOP) begin
        remote_next = remote_next + srv_sync_pkg::LEVEL_ONE;
      end else if (mode_reg == srv_sync_pkg::MODE_DOWN &&
                   remote_next > srv_sync_pkg::LEVEL_FLOOR) begin
        remote_next = remote_next - srv_sync_pkg::LEVEL_ONE;
      end
    end

    if (s1_req == srv_sync_pkg::REQ_STOP ||
        (s1_req == srv_sync_pkg::REQ_DONE && busy_reg && s1_err)) begin
      mode_next = srv_sync_pkg::MODE_WAIT;
    end
    if (s1_req == srv_sync_pkg::REQ_RESET) begin
      remote_next = srv_sync_pkg::LEVEL_UNSYNC;
    end

    if (do_adv) begin
      mode_next = srv_sync_pkg::MODE_WAIT;
      if (target_next != remote_next) begin
        applied_next = target_next;
        // drop to zero from above one waits out the long delay first
        if (applied_next == srv_sync_pkg::LEVEL_ZERO && prev > srv_sync_pkg::LEVEL_ONE) begin
          mode_next = srv_sync_pkg::MODE_DELAY;
        end else if (applied_next > remote_next) begin
          mode_next = (mode_prior == srv_sync_pkg::MODE_UP_TIMING) ?
                      srv_sync_pkg::MODE_UP : srv_sync_pkg::MODE_UP_TIMING;
        end else if (applied_next < remote_next) begin
          mode_next = (mode_prior == srv_sync_pkg::MODE_DOWN_TIMING) ?
                      srv_sync_pkg::MODE_DOWN : srv_sync_pkg::MODE_DOWN_TIMING;
        end
      end
      unique case (mode_next)
        srv_sync_pkg::MODE_UP_TIMING,
        srv_sync_pkg::MODE_DOWN_TIMING: want = srv_sync_pkg::ACT_SHORT;
        srv_sync_pkg::MODE_UP:          want = srv_sync_pkg::ACT_UP;
        srv_sync_pkg::MODE_DOWN:        want = srv_sync_pkg::ACT_DOWN;
        srv_sync_pkg::MODE_DELAY:       want = srv_sync_pkg::ACT_LONG;
        default:                        want = srv_sync_pkg::ACT_NONE;
      endcase
      // nothing starts while a request is still pending
      if (want != srv_sync_pkg::ACT_NONE && !busy_next) begin
        busy_next = 1'b1;
        act_next  = want;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
      mode_reg      <= srv_sync_pkg::MODE_WAIT;
      target_level  <= srv_sync_pkg::LEVEL_UNSYNC;
      applied_level <= srv_sync_pkg::LEVEL_UNSYNC;
      remote_reg    <= srv_sync_pkg::LEVEL_UNSYNC;
      busy_reg      <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid     <= 1'b1;
        mode_reg      <= mode_next;
        target_level  <= target_next;
        applied_level <= applied_next;
        remote_reg    <= remote_next;
        busy_reg      <= busy_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_req <= srv_sync_pkg::req_t'(req_type);
      s1_vol <= new_volume;
      s1_err <= completion_error;
    end
    if (s1_move) begin
      action       <= act_next;
      mode         <= mode_next;
      remote_level <= remote_next;
    end
  end

  `SRV_ASSERT_IMPLIES(a_start_marks_busy, clk, rst,
                      s1_move && act_next != srv_sync_pkg::ACT_NONE, busy_next)
  `SRV_ASSERT_IMPLIES(a_stall_only_when_full, clk, rst, in_stall,
                      s1_valid && out_valid && out_stall)
  `SRV_ASSERT_NEXT(a_eval_gives_result, clk, rst, s1_move, out_valid)

endmodule
